FILE: design/bvm_pkg.sv
`default_nettype none
package bvm_pkg;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_ALPHA    = 3'd0,
    REG_WARN     = 3'd1,
    REG_CRIT     = 3'd2,
    REG_VREF     = 3'd3,
    REG_SAG_RATE = 3'd4
  } bvm_reg_t;

  // Filter weight limits, 1/256 units
  localparam logic [7:0] ALPHA_MIN = 8'd3;
  localparam logic [7:0] ALPHA_MAX = 8'd128;

  // Compensation: 9000 mV floor in Q8, clamp limits in Q1.14
  localparam logic [22:0] COMP_FLOOR_Q8 = 23'd2304000;
  localparam logic [14:0] COMP_MIN_Q14  = 15'd13926;
  localparam logic [14:0] COMP_MAX_Q14  = 15'd20480;

  // Microseconds per second, scales the voltage drop in the sag test
  localparam logic [19:0] US_PER_S = 20'd1000000;

  // Iteration counts of the serial units
  localparam int IIR_STEPS = 8;
  localparam int SAG_STEPS = 23;
  localparam int DIV_STEPS = 16;
  localparam int IIR_CW    = $clog2(IIR_STEPS);
  localparam int SAG_CW    = $clog2(SAG_STEPS);
  localparam int DIV_CW    = $clog2(DIV_STEPS);

endpackage
`default_nettype wire

FILE: design/battery_voltage_monitor_top.sv
`default_nettype none
// Battery voltage monitor.
// Input stream s_*: one word per sample, bus_word (raw bus-voltage register)
// and elapsed_us (time since the previous sample). Output stream m_*: one
// word per sample with raw mV, filtered mV in Q8, warn, critical and sag
// flags and the compensation factor in Q1.14.
// Configuration: cfg_we with cfg_addr selecting alpha, warn, critical,
// vref or sag rate; cfg_data carries the value. Write only while idle.
// Steps of a sample after acceptance: the bit-serial filter multiplier,
// then the bit-serial sag multipliers, which run beside the divider, and
// last the done state, which loads the output register once it is free.
// One sample is in work at a time.
// s_tready is high only while no sample is in work; a finished word waits
// in the output register while the next sample is taken. If the receiver
// stalls, a finished result holds in the unit until the output is free.
// Reset clears the filter, the priming and sag flags, empties the output
// and loads the default configuration.
module battery_voltage_monitor_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // bus_word[15:0], elapsed_us[39:16]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0] m_tdata,        // raw_mv[14:0], filtered_mv_q8[37:15],
                                      // warn[38], critical[39], sag[40],
                                      // comp_factor_q14[55:41]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_data
);
  import bvm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILT,
    S_EVAL,
    S_DONE
  } state_t;

  state_t      state;
  logic [7:0]  alpha_q8;
  logic [14:0] warn_mv;
  logic [14:0] crit_mv;
  logic [14:0] vref_mv;
  logic [15:0] sag_rate;
  logic [22:0] filt_q8;
  logic        primed;
  logic        sag_flag;
  logic [14:0] raw_r;
  logic [23:0] dt_r;
  logic [22:0] new_filt;

  logic        filt_start;
  logic        eval_start;
  logic        filt_done;
  logic [22:0] filt_res;
  logic [22:0] filt_sel;
  logic        sag_done;
  logic        sag_fall;
  logic        div_done;
  logic [14:0] comp_q14;
  logic        sag_next;
  logic        out_free;
  logic [14:0] in_raw;

  assign in_raw     = {s_tdata[15:3], 2'b00};
  assign s_tready   = (state == S_IDLE);
  assign filt_start = (state == S_IDLE) && s_tvalid;
  assign eval_start = (state == S_FILT) && filt_done;
  assign filt_sel   = primed ? filt_res : {raw_r, 8'd0};
  assign out_free   = !m_tvalid || m_tready;

  // Sag flag holds on the priming sample and on zero elapsed time
  always_comb begin
    if (primed && (dt_r != 24'd0)) begin
      sag_next = (new_filt < filt_q8) && sag_fall;
    end else begin
      sag_next = sag_flag;
    end
  end

  bvm_iir u_iir (
    .clk    (clk),
    .rst    (rst),
    .start  (filt_start),
    .alpha  (alpha_q8),
    .prev   (filt_q8),
    .sample ({in_raw, 8'd0}),
    .done   (filt_done),
    .result (filt_res)
  );

  bvm_sag u_sag (
    .clk   (clk),
    .rst   (rst),
    .start (eval_start),
    .prev  (filt_q8),
    .next  (filt_sel),
    .dt    (dt_r),
    .rate  (sag_rate),
    .done  (sag_done),
    .fall  (sag_fall)
  );

  bvm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (eval_start),
    .vref  (vref_mv),
    .vf    (filt_sel),
    .done  (div_done),
    .quot  (comp_q14)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_q8 <= 8'd26;
      warn_mv  <= 15'd11200;
      crit_mv  <= 15'd10800;
      vref_mv  <= 15'd11100;
      sag_rate <= 16'd150;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ALPHA:    alpha_q8 <= cfg_data[7:0];
        REG_WARN:     warn_mv  <= cfg_data[14:0];
        REG_CRIT:     crit_mv  <= cfg_data[14:0];
        REG_VREF:     vref_mv  <= cfg_data[14:0];
        REG_SAG_RATE: sag_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequence one sample and hold the state and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      filt_q8  <= '0;
      primed   <= 1'b0;
      sag_flag <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // Drop a taken word unless the done state reloads the register
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            raw_r <= in_raw;
            dt_r  <= s_tdata[39:16];
            state <= S_FILT;
          end
        end
        S_FILT: begin
          if (filt_done) begin
            new_filt <= filt_sel;
            state    <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (sag_done && div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            filt_q8  <= new_filt;
            primed   <= 1'b1;
            sag_flag <= sag_next;
            m_tvalid <= 1'b1;
            m_tdata  <= {comp_q14, sag_next,
                         new_filt <= {crit_mv, 8'd0},
                         new_filt <= {warn_mv, 8'd0},
                         new_filt, raw_r};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/bvm_iir.sv
`default_nettype none
module bvm_iir (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [7:0]  alpha,
  input  wire logic [22:0] prev,
  input  wire logic [22:0] sample,
  output logic             done,
  output logic [22:0]      result
);
  import bvm_pkg::*;

  logic [30:0]       acc;
  logic [7:0]        a_sh;
  logic [7:0]        b_sh;
  logic [22:0]       prev_r;
  logic [22:0]       samp_r;
  logic [IIR_CW-1:0] cnt;
  logic              busy;
  logic [7:0]        a_clamp;
  logic [23:0]       partial;

  // Clamp the filter weight
  always_comb begin
    if (alpha < ALPHA_MIN) begin
      a_clamp = ALPHA_MIN;
    end else if (alpha > ALPHA_MAX) begin
      a_clamp = ALPHA_MAX;
    end else begin
      a_clamp = alpha;
    end
  end

  // One bit of each weight per cycle, most significant first
  always_comb begin
    partial = (a_sh[7] ? {1'b0, samp_r} : 24'd0) + (b_sh[7] ? {1'b0, prev_r} : 24'd0);
  end

  // Shift-add over the weight bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy   <= 1'b1;
      done   <= 1'b0;
      cnt    <= '0;
      acc    <= '0;
      a_sh   <= a_clamp;
      b_sh   <= 8'(9'd256 - {1'b0, a_clamp});
      prev_r <= prev;
      samp_r <= sample;
    end else if (busy) begin
      acc  <= {acc[29:0], 1'b0} + {7'd0, partial};
      a_sh <= {a_sh[6:0], 1'b0};
      b_sh <= {b_sh[6:0], 1'b0};
      cnt  <= cnt + 1'b1;
      if (cnt == IIR_CW'(IIR_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Drop the eight fraction bits of the weights
  assign result = acc[30:8];

endmodule
`default_nettype wire

FILE: design/bvm_sag.sv
`default_nettype none
module bvm_sag (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [22:0] prev,
  input  wire logic [22:0] next,
  input  wire logic [23:0] dt,
  input  wire logic [15:0] rate,
  output logic             done,
  output logic             fall
);
  import bvm_pkg::*;

  logic [22:0]       d_sh;
  logic [22:0]       r_sh;
  logic [23:0]       dt_r;
  logic [42:0]       lhs;
  logic [46:0]       rhs;
  logic [SAG_CW-1:0] cnt;
  logic              busy;

  // Drop times 1e6 against rate times 128 times dt, one bit of each per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      lhs  <= '0;
      rhs  <= '0;
      d_sh <= prev - next;
      r_sh <= {rate, 7'd0};
      dt_r <= dt;
    end else if (busy) begin
      lhs  <= {lhs[41:0], 1'b0} + (d_sh[22] ? {23'd0, US_PER_S} : 43'd0);
      rhs  <= {rhs[45:0], 1'b0} + (r_sh[22] ? {23'd0, dt_r} : 47'd0);
      d_sh <= {d_sh[21:0], 1'b0};
      r_sh <= {r_sh[21:0], 1'b0};
      cnt  <= cnt + 1'b1;
      if (cnt == SAG_CW'(SAG_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // The doubled right side restores the factor 256
  assign fall = {5'd0, lhs} > {rhs, 1'b0};

endmodule
`default_nettype wire

FILE: design/bvm_div.sv
`default_nettype none
module bvm_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [14:0] vref,
  input  wire logic [22:0] vf,
  output logic             done,
  output logic [14:0]      quot
);
  import bvm_pkg::*;

  logic [22:0]       den;
  logic [22:0]       rem;
  logic [15:0]       quo;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic [24:0]       diff;
  logic              ge;

  // Trial subtract of the shifted remainder
  always_comb begin
    diff = {1'b0, rem, 1'b0} - {2'b00, den};
    ge   = ~diff[24];
  end

  // Restoring division, one quotient bit per cycle; the high dividend
  // bits start below the floored divisor, the low ones are all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      quo  <= '0;
      den  <= (vf < COMP_FLOOR_Q8) ? COMP_FLOOR_Q8 : vf;
      rem  <= {2'b00, vref, 6'd0};
    end else if (busy) begin
      rem <= ge ? diff[22:0] : {rem[21:0], 1'b0};
      quo <= {quo[14:0], ge};
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CW'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Clamp the factor
  always_comb begin
    if (quo < {1'b0, COMP_MIN_Q14}) begin
      quot = COMP_MIN_Q14;
    end else if (quo > {1'b0, COMP_MAX_Q14}) begin
      quot = COMP_MAX_Q14;
    end else begin
      quot = quo[14:0];
    end
  end

endmodule
`default_nettype wire
